### rtl/npas_pkg.sv
// shared types, constants and the cordic arctangent table for nearest_point_align_steer
// no dependencies

package npas_pkg;

  // coordinate and squared range widths
  localparam int COORD_WIDTH = 16;
  localparam int SQ_W        = 2 * COORD_WIDTH;
  localparam logic [SQ_W-1:0] MIN_RANGE_SQ = SQ_W'(100);

  // configuration register widths and reset values
  localparam int THR_W   = 15;
  localparam int ANG_W   = 16;
  localparam int SPEED_W = 15;
  localparam int THR_SQ_W = 2 * THR_W;
  localparam int CMP_W   = (SQ_W > THR_SQ_W) ? SQ_W : THR_SQ_W;

  localparam logic [THR_W-1:0]          THR_RESET   = THR_W'(1000);
  localparam logic signed [ANG_W-1:0]   TARGET_RESET = '0;
  localparam logic [ANG_W-1:0]          TOL_RESET   = ANG_W'(820);
  localparam logic [SPEED_W-1:0]        SPEED_RESET = SPEED_W'(4096);

  // configuration port
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_DIST_THR  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED     = CFG_IDX_W'(3);

  // cordic
  localparam int CORDIC_STEPS = 16;
  localparam int STEP_W    = $clog2(CORDIC_STEPS);
  localparam int TAB_IDX_W = 5;
  localparam int CX_W      = COORD_WIDTH + 3;
  localparam int CZ_W      = 20;
  localparam int AT_W      = CZ_W - 3;
  localparam int ERR_W     = 20;
  localparam logic signed [CZ_W-1:0] HALF_PI_Q16 = CZ_W'(102944);
  localparam logic signed [CZ_W-1:0] ROUND_Q13   = CZ_W'(4);

  // result codes
  typedef enum logic [1:0] {
    ST_NO_DATA  = 2'd0,
    ST_NO_SHORE = 2'd1,
    ST_ALIGNED  = 2'd2,
    ST_TURNING  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_SCAN,
    S_DRAIN,
    S_CHECK,
    S_CORDIC,
    S_ANGLE,
    S_DECIDE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic    cordic_load;
    logic    cordic_step;
    logic    err_load;
    logic    result_load;
    status_t code;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_done;
    logic found;
    logic over_thr;
    logic step_last;
    logic aligned;
  } dp_stat_t;

  // round(atan(2^-i) * 2^16)
  function automatic logic signed [CZ_W-1:0] atan_tab(input logic [TAB_IDX_W-1:0] i);
    logic signed [CZ_W-1:0] v;
    unique case (i)
      5'd0:    v = CZ_W'(51472);
      5'd1:    v = CZ_W'(30386);
      5'd2:    v = CZ_W'(16055);
      5'd3:    v = CZ_W'(8150);
      5'd4:    v = CZ_W'(4091);
      5'd5:    v = CZ_W'(2047);
      5'd6:    v = CZ_W'(1024);
      5'd7:    v = CZ_W'(512);
      5'd8:    v = CZ_W'(256);
      5'd9:    v = CZ_W'(128);
      5'd10:   v = CZ_W'(64);
      5'd11:   v = CZ_W'(32);
      5'd12:   v = CZ_W'(16);
      5'd13:   v = CZ_W'(8);
      5'd14:   v = CZ_W'(4);
      5'd15:   v = CZ_W'(2);
      5'd16:   v = CZ_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/npas_in_if.sv
// scan point channel: valid, ready and one point per beat
// depends on npas_pkg

interface npas_in_if;
  logic                                    valid;
  logic                                    ready;
  logic signed [npas_pkg::COORD_WIDTH-1:0] point_x;
  logic signed [npas_pkg::COORD_WIDTH-1:0] point_y;
  logic                                    last_point;

  modport source(output valid, point_x, point_y, last_point, input ready);
  modport sink(input valid, point_x, point_y, last_point, output ready);
endinterface

### rtl/npas_out_if.sv
// result channel: valid, ready, status and rotation command per beat
// depends on npas_pkg

interface npas_out_if;
  logic               valid;
  logic               ready;
  npas_pkg::status_t  status;
  logic signed [15:0] rotation_command;

  modport source(output valid, status, rotation_command, input ready);
  modport sink(input valid, status, rotation_command, output ready);
endinterface

### rtl/npas_cfg_if.sv
// configuration write channel: valid, ready, register index and write data
// depends on npas_pkg

interface npas_cfg_if;
  logic                                 valid;
  logic                                 ready;
  logic [npas_pkg::CFG_IDX_W-1:0]       index;
  logic [npas_pkg::CFG_DATA_W-1:0]      data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/nearest_point_align_steer.sv
// top level of the nearest point alignment steering block
// depends on npas_pkg, npas_in_if, npas_out_if, npas_cfg_if, npas_ctrl, npas_dp
//
// usage
//   in_ch carries scan points (point_x, point_y in mm) with last_point on the final
//   point of a scan; one beat per cycle is taken while a scan streams in
//   each point goes through a two stage squared range pipeline (square, then add and
//   compare against the running minimum), so the nearest point above 10 mm is kept
//   the beat with last_point drops in_ch.ready until the scan's result is taken
//   out_ch then carries one beat per scan: status and rotation_command
//   out_ch.valid rises once the control has gone from S_DRAIN through S_CHECK to S_OUT
//   for no data or no shore; when the bearing is needed it first runs CORDIC_STEPS
//   rotations in S_CORDIC, one rotation per cycle, then S_ANGLE and S_DECIDE
//   the first point of the next scan can be taken in the cycle after the result beat
//   if out_ch.ready is low the result holds in its output register and no new scan
//   starts until it is taken
//   cfg_ch is always ready; registers are index 0 distance threshold, 1 target angle,
//   2 angle tolerance, 3 turn speed; other indexes are ignored
//   synchronous reset (rst_n low) restores the register defaults, clears the running
//   minimum and the found flag, and empties the pipeline and result channel

module nearest_point_align_steer (
  input  logic              clk,
  input  logic              rst_n,
  npas_in_if.sink           in_ch,
  npas_out_if.source        out_ch,
  npas_cfg_if.sink          cfg_ch
);

  npas_pkg::ctrl_cmd_t cmd;
  npas_pkg::dp_stat_t  stat;
  logic                in_ready;
  logic                out_valid;
  logic                in_acc;

  // config writes never stall
  assign cfg_ch.ready = 1'b1;

  assign in_ch.ready = in_ready;
  assign in_acc      = in_ch.valid && in_ready;

  assign out_ch.valid = out_valid;

  // sequencing: scan, drain the range pipeline, check, cordic, decide, hand off
  npas_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_last_point (in_ch.last_point),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ch.ready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // arithmetic and all storage but the control state register
  npas_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_acc     (in_acc),
    .in_x       (in_ch.point_x),
    .in_y       (in_ch.point_y),
    .in_last    (in_ch.last_point),
    .cfg_we     (cfg_ch.valid),
    .cfg_idx    (cfg_ch.index),
    .cfg_data   (cfg_ch.data),
    .cmd        (cmd),
    .stat       (stat),
    .out_status (out_ch.status),
    .out_rot    (out_ch.rotation_command)
  );

endmodule

### rtl/npas_ctrl.sv
// control state machine: scan, drain, range check, cordic run, decision, result hand-off
// depends on npas_pkg

module npas_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_last_point,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  npas_pkg::dp_stat_t  stat,
  output npas_pkg::ctrl_cmd_t cmd
);

  npas_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= npas_pkg::S_SCAN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    out_valid       = 1'b0;
    cmd.cordic_load = 1'b0;
    cmd.cordic_step = 1'b0;
    cmd.err_load    = 1'b0;
    cmd.result_load = 1'b0;
    cmd.code        = npas_pkg::ST_NO_DATA;
    unique case (state_r)
      npas_pkg::S_SCAN: begin
        in_ready = 1'b1;
        if (in_valid && in_last_point) begin
          state_nxt = npas_pkg::S_DRAIN;
        end
      end
      npas_pkg::S_DRAIN: begin
        if (stat.last_done) begin
          state_nxt = npas_pkg::S_CHECK;
        end
      end
      npas_pkg::S_CHECK: begin
        if (!stat.found) begin
          cmd.result_load = 1'b1;
          cmd.code        = npas_pkg::ST_NO_DATA;
          state_nxt       = npas_pkg::S_OUT;
        end else if (stat.over_thr) begin
          cmd.result_load = 1'b1;
          cmd.code        = npas_pkg::ST_NO_SHORE;
          state_nxt       = npas_pkg::S_OUT;
        end else begin
          cmd.cordic_load = 1'b1;
          state_nxt       = npas_pkg::S_CORDIC;
        end
      end
      npas_pkg::S_CORDIC: begin
        cmd.cordic_step = 1'b1;
        if (stat.step_last) begin
          state_nxt = npas_pkg::S_ANGLE;
        end
      end
      npas_pkg::S_ANGLE: begin
        cmd.err_load = 1'b1;
        state_nxt    = npas_pkg::S_DECIDE;
      end
      npas_pkg::S_DECIDE: begin
        cmd.result_load = 1'b1;
        cmd.code        = stat.aligned ? npas_pkg::ST_ALIGNED : npas_pkg::ST_TURNING;
        state_nxt       = npas_pkg::S_OUT;
      end
      npas_pkg::S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = npas_pkg::S_SCAN;
        end
      end
      default: begin
        state_nxt = npas_pkg::S_SCAN;
      end
    endcase
  end

endmodule

### rtl/npas_dp.sv
// datapath: config registers, squared range pipeline, nearest point, cordic, result register
// depends on npas_pkg

module npas_dp (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_acc,
  input  logic signed [npas_pkg::COORD_WIDTH-1:0] in_x,
  input  logic signed [npas_pkg::COORD_WIDTH-1:0] in_y,
  input  logic                                    in_last,
  input  logic                                    cfg_we,
  input  logic [npas_pkg::CFG_IDX_W-1:0]          cfg_idx,
  input  logic [npas_pkg::CFG_DATA_W-1:0]         cfg_data,
  input  npas_pkg::ctrl_cmd_t                     cmd,
  output npas_pkg::dp_stat_t                      stat,
  output npas_pkg::status_t                       out_status,
  output logic signed [15:0]                      out_rot
);

  localparam int CW = npas_pkg::COORD_WIDTH;

  // config registers
  logic [npas_pkg::THR_W-1:0]        thr_r;
  logic signed [npas_pkg::ANG_W-1:0] target_r;
  logic [npas_pkg::ANG_W-1:0]        tol_r;
  logic [npas_pkg::SPEED_W-1:0]      speed_r;
  logic [npas_pkg::THR_SQ_W-1:0]     thr_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r    <= npas_pkg::THR_RESET;
      target_r <= npas_pkg::TARGET_RESET;
      tol_r    <= npas_pkg::TOL_RESET;
      speed_r  <= npas_pkg::SPEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        npas_pkg::CFG_DIST_THR:  thr_r    <= cfg_data[npas_pkg::THR_W-1:0];
        npas_pkg::CFG_TARGET:    target_r <= signed'(cfg_data[npas_pkg::ANG_W-1:0]);
        npas_pkg::CFG_TOLERANCE: tol_r    <= cfg_data[npas_pkg::ANG_W-1:0];
        npas_pkg::CFG_SPEED:     speed_r  <= cfg_data[npas_pkg::SPEED_W-1:0];
        default: ;
      endcase
    end
  end

  // threshold squared, refreshed every cycle
  always_ff @(posedge clk) begin
    thr_sq_r <= thr_r * thr_r;
  end

  // stage 1: squares
  logic signed [npas_pkg::SQ_W-1:0] sqx, sqy;
  logic                             p1_vld_r, p1_last_r;
  logic [npas_pkg::SQ_W-1:0]        p1_sqx_r, p1_sqy_r;
  logic signed [CW-1:0]             p1_x_r, p1_y_r;

  assign sqx = in_x * in_x;
  assign sqy = in_y * in_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_vld_r <= 1'b0;
    end else begin
      p1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      p1_sqx_r  <= unsigned'(sqx);
      p1_sqy_r  <= unsigned'(sqy);
      p1_x_r    <= in_x;
      p1_y_r    <= in_y;
      p1_last_r <= in_last;
    end
  end

  // stage 2: sum and running minimum
  logic [npas_pkg::SQ_W-1:0] r2;
  logic [npas_pkg::SQ_W-1:0] best_r2_r;
  logic signed [CW-1:0]      best_x_r, best_y_r;
  logic                      found_r;
  logic                      take;

  assign r2   = p1_sqx_r + p1_sqy_r;
  assign take = p1_vld_r && (r2 > npas_pkg::MIN_RANGE_SQ) && (r2 < best_r2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_r2_r <= '1;
      found_r   <= 1'b0;
      best_x_r  <= '0;
      best_y_r  <= '0;
    end else if (cmd.result_load) begin
      best_r2_r <= '1;
      found_r   <= 1'b0;
    end else if (take) begin
      best_r2_r <= r2;
      found_r   <= 1'b1;
      best_x_r  <= p1_x_r;
      best_y_r  <= p1_y_r;
    end
  end

  // cordic, vectoring mode
  logic signed [npas_pkg::CX_W-1:0] cx_r, cy_r, bx, by, dx, dy;
  logic signed [npas_pkg::CZ_W-1:0] cz_r, tab, z_rnd;
  logic [npas_pkg::STEP_W-1:0]      step_r;

  assign bx  = npas_pkg::CX_W'(best_x_r);
  assign by  = npas_pkg::CX_W'(best_y_r);
  assign dx  = cy_r >>> step_r;
  assign dy  = cx_r >>> step_r;
  assign tab = npas_pkg::atan_tab(npas_pkg::TAB_IDX_W'(step_r));

  always_ff @(posedge clk) begin
    if (cmd.cordic_load) begin
      step_r <= '0;
      if (best_x_r < 0) begin
        if (best_y_r >= 0) begin
          cx_r <= by;
          cy_r <= -bx;
          cz_r <= npas_pkg::HALF_PI_Q16;
        end else begin
          cx_r <= -by;
          cy_r <= bx;
          cz_r <= -npas_pkg::HALF_PI_Q16;
        end
      end else begin
        cx_r <= bx;
        cy_r <= by;
        cz_r <= '0;
      end
    end else if (cmd.cordic_step) begin
      step_r <= step_r + 1'b1;
      if (cy_r > 0) begin
        cx_r <= cx_r + dx;
        cy_r <= cy_r - dy;
        cz_r <= cz_r + tab;
      end else begin
        cx_r <= cx_r - dx;
        cy_r <= cy_r + dy;
        cz_r <= cz_r - tab;
      end
    end
  end

  // error = target - bearing = target + atan2
  logic signed [npas_pkg::ERR_W-1:0] err_r, err_mag;
  logic signed [npas_pkg::AT_W-1:0]  atan_q13;

  assign z_rnd    = cz_r + npas_pkg::ROUND_Q13;
  assign atan_q13 = z_rnd[npas_pkg::CZ_W-1:3];

  always_ff @(posedge clk) begin
    if (cmd.err_load) begin
      err_r <= npas_pkg::ERR_W'(target_r) + npas_pkg::ERR_W'(atan_q13);
    end
  end

  assign err_mag = (err_r < 0) ? -err_r : err_r;

  // result register
  logic signed [15:0] speed_s;
  npas_pkg::status_t  status_r;
  logic signed [15:0] rot_r;

  assign speed_s = signed'(16'(speed_r));

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      status_r <= cmd.code;
      if (cmd.code == npas_pkg::ST_TURNING) begin
        rot_r <= (err_r > 0) ? -speed_s : speed_s;
      end else begin
        rot_r <= '0;
      end
    end
  end

  assign out_status = status_r;
  assign out_rot    = rot_r;

  assign stat.last_done = p1_vld_r && p1_last_r;
  assign stat.found     = found_r;
  assign stat.over_thr  = npas_pkg::CMP_W'(best_r2_r) > npas_pkg::CMP_W'(thr_sq_r);
  assign stat.step_last = (step_r == npas_pkg::STEP_W'(npas_pkg::CORDIC_STEPS - 1));
  assign stat.aligned   = err_mag < npas_pkg::ERR_W'(tol_r);

endmodule
